[rtl/core/blpm_pkg.sv]
// ----------------------------------------------------------------------------
// blpm_pkg
// Shared widths, codes and types of the base/limit protected word memory.
// ----------------------------------------------------------------------------
package blpm_pkg;

    localparam int MEMORY_WORDS = 2048;
    localparam int ADDR_W       = $clog2(MEMORY_WORDS);

    localparam int DATA_W  = 27;
    localparam int LADDR_W = 13;
    localparam int PHYS_W  = LADDR_W + 1;
    localparam int BASE_W  = 11;
    localparam int LEN_W   = 12;
    localparam int RESV_W  = 12;
    localparam int CFG_W   = 12;
    localparam int CIDX_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    localparam logic [RESV_W-1:0] RESV_RESET = RESV_W'(300);

    localparam logic [CIDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_LEN  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_RESV = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_REGION = 2'd1;
    localparam logic [1:0] STATUS_BOUNDS = 2'd2;
    localparam logic [1:0] STATUS_PRIV   = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic              irq;
    } access_t;

endpackage

[rtl/core/blpm_ram.sv]
// ----------------------------------------------------------------------------
// blpm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module blpm_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[rtl/core/blpm_front.sv]
// ----------------------------------------------------------------------------
// blpm_front
// Configuration registers, input beat acceptance and access classification.
// ----------------------------------------------------------------------------
module blpm_front
    import blpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CIDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 clearing,
    input  logic                 q_full,
    output logic                 q_push,
    output access_t              q_entry
);

    logic [BASE_W-1:0]  base_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [RESV_W-1:0]  resv_reg;

    logic [LADDR_W-1:0] laddr;
    logic               neg;
    logic               translate;
    logic [PHYS_W-1:0]  phys;
    logic               region_fail;
    logic               bounds_fail;
    logic               priv_fail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            len_reg  <= '0;
            resv_reg <= RESV_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE: base_reg <= cfg_wdata[BASE_W-1:0];
                CFG_LEN:  len_reg  <= cfg_wdata[LEN_W-1:0];
                CFG_RESV: resv_reg <= cfg_wdata[RESV_W-1:0];
                default:  ;
            endcase
        end
    end

    assign laddr     = s_tdata[LADDR_W-1:0];
    assign neg       = laddr[LADDR_W-1];
    assign translate = (base_reg != '0) || (len_reg != '0);
    assign phys      = {laddr[LADDR_W-1], laddr} + PHYS_W'(base_reg);

    // non-negative logical address: phys >= base + len <=> logical >= len
    assign region_fail = neg || (translate && (laddr[LEN_W-1:0] >= len_reg));
    assign bounds_fail = phys >= PHYS_W'(MEMORY_WORDS);
    assign priv_fail   = s_tuser[1] && (phys < PHYS_W'(resv_reg));

    always_comb begin
        q_entry.op   = s_tuser[0];
        q_entry.addr = phys[ADDR_W-1:0];
        q_entry.data = s_tdata[LADDR_W +: DATA_W];
        if (region_fail) begin
            q_entry.status = STATUS_REGION;
            q_entry.irq    = translate;
        end else if (bounds_fail) begin
            q_entry.status = STATUS_BOUNDS;
            q_entry.irq    = 1'b0;
        end else if (priv_fail) begin
            q_entry.status = STATUS_PRIV;
            q_entry.irq    = 1'b1;
        end else begin
            q_entry.status = STATUS_OK;
            q_entry.irq    = 1'b0;
        end
    end

    assign s_tready = !clearing && !q_full;
    assign q_push   = s_tvalid && s_tready;

endmodule

[rtl/core/blpm_queue.sv]
// ----------------------------------------------------------------------------
// blpm_queue
// Short FIFO of classified accesses between the front and the back.
// ----------------------------------------------------------------------------
module blpm_queue
    import blpm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  access_t push_entry,
    output logic    full,
    input  logic    pop,
    output access_t head,
    output logic    empty
);

    access_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/core/blpm_back.sv]
// ----------------------------------------------------------------------------
// blpm_back
// Memory clearing pass, access execution on the word RAM and result register.
// ----------------------------------------------------------------------------
module blpm_back
    import blpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_empty,
    input  access_t              q_head,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    logic              clr_busy_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic              pend_reg;
    logic              pend_rd_reg;
    logic [1:0]        pend_status_reg;
    logic              pend_irq_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [1:0]        out_status_reg;
    logic              out_irq_reg;

    logic              ok;
    logic              ram_en;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    assign ok    = q_head.status == STATUS_OK;
    assign q_pop = !clr_busy_reg && !q_empty && !pend_reg && (!out_valid_reg || m_tready);

    assign ram_en    = clr_busy_reg || (q_pop && ok);
    assign ram_we    = clr_busy_reg || (q_head.op == OP_WRITE);
    assign ram_addr  = clr_busy_reg ? clr_addr_reg : q_head.addr;
    assign ram_wdata = clr_busy_reg ? '0 : q_head.data;

    blpm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEMORY_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(MEMORY_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= q_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pend_rd_reg     <= ok && (q_head.op == OP_READ);
            pend_status_reg <= q_head.status;
            pend_irq_reg    <= q_head.irq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            out_data_reg   <= pend_rd_reg ? ram_rdata : '0;
            out_status_reg <= pend_status_reg;
            out_irq_reg    <= pend_irq_reg;
        end
    end

    assign clearing = clr_busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);
    assign m_tuser  = {out_irq_reg, out_status_reg};

endmodule

[rtl/core/base_limit_protected_memory_unit.sv]
// Path: an accepted beat is stored in the queue, issued from the queue head to
// the single RAM port, and its result passes the pending registers into the
// result register; no new access issues while one is pending or stalled.
// Reset: synchronous; afterwards a clearing pass writes zero to all
// MEMORY_WORDS (2048) words, one per cycle, with s_tready held low.
// ----------------------------------------------------------------------------
// base_limit_protected_memory_unit
// Word memory behind base/limit relocation with region, bounds and
// privilege checks; returns a status code and an interrupt flag per access.
// ----------------------------------------------------------------------------
module base_limit_protected_memory_unit
    import blpm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CIDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // program address, write_data
    input  logic [S_TUSER_W-1:0] s_tuser,   // operation, user flag
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // read_data, zero fill
    output logic [M_TUSER_W-1:0] m_tuser    // status, raise_interrupt
);

    access_t push_entry;
    access_t head;
    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    logic    clearing;

    blpm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    blpm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    blpm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (empty),
        .q_head   (head),
        .q_pop    (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/core/blpm_checker.sv]
// ----------------------------------------------------------------------------
// blpm_checker
// Port-level checks of the protected memory, bound to the top level.
// ----------------------------------------------------------------------------
module blpm_checker
    import blpm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("beat offered right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    a_irq_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |->
            m_tuser[1:0] == STATUS_REGION || m_tuser[1:0] == STATUS_PRIV)
        else $error("interrupt with wrong status");

    a_data_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata != '0) |-> m_tuser[1:0] == STATUS_OK)
        else $error("read data on a faulting access");

    a_bounds_no_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == STATUS_BOUNDS || m_tuser[1:0] == STATUS_OK)
            |-> !m_tuser[2])
        else $error("interrupt on bounds or ok status");

endmodule

bind base_limit_protected_memory_unit blpm_checker u_blpm_checker (.*);
